FILE: design/md5_pkg.sv
// Shared types, codes and round constants of the MD5 digest engine.
package md5_pkg;

    localparam int WORD_W  = 32;
    localparam int FILL_W  = 6;
    localparam int COUNT_W = 61;
    localparam int ROUND_W = 6;
    localparam int DIGEST_W = 128;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [WORD_W-1:0] INIT_A = 32'h67452301;
    localparam logic [WORD_W-1:0] INIT_B = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] INIT_C = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] INIT_D = 32'h10325476;
    localparam logic [7:0]        PAD_BYTE = 8'h80;

    localparam logic [WORD_W-1:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_LOAD,
        ST_EMIT
    } md5_state_t;

    // How the block words are presented to the rounds.
    typedef enum logic [1:0] {
        BLK_DATA,    // stored bytes as they are
        BLK_PAD,     // stored bytes, then 0x80, then zeros
        BLK_PADLEN,  // as BLK_PAD with the bit count in words 14 and 15
        BLK_ZLEN     // all zeros with the bit count in words 14 and 15
    } md5_blk_mode_t;

    typedef struct packed {
        logic          byte_wr;
        logic          comp_start;
        logic          round_step;
        logic          chain_add;
        logic          emit;
        md5_blk_mode_t blk_mode;
    } md5_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic fill_late;
        logic round_last;
        logic out_free;
    } md5_stat_t;

endpackage

FILE: design/md5_ctrl.sv
// Sequencer of the MD5 engine: byte intake, compressions and digest hand-off.
module md5_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              kind,
    input  md5_pkg::md5_stat_t stat,
    output md5_pkg::md5_cmd_t  cmd
);
    import md5_pkg::*;

    md5_state_t    state_reg, state_next;
    md5_blk_mode_t mode_reg, mode_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= BLK_DATA;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cmd            = '0;
        cmd.blk_mode   = mode_reg;
        s_tready       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (kind == KIND_DATA) begin
                        cmd.byte_wr = 1'b1;
                        if (stat.fill_last) begin
                            cmd.comp_start = 1'b1;
                            mode_next      = BLK_DATA;
                            state_next     = ST_ROUND;
                        end
                    end else begin
                        cmd.comp_start = 1'b1;
                        mode_next      = stat.fill_late ? BLK_PAD : BLK_PADLEN;
                        state_next     = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                if (stat.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.chain_add = 1'b1;
                case (mode_reg)
                    BLK_DATA: state_next = ST_IDLE;
                    BLK_PAD: begin
                        mode_next  = BLK_ZLEN;
                        state_next = ST_LOAD;
                    end
                    default: state_next = ST_EMIT;
                endcase
            end
            ST_LOAD: begin
                cmd.comp_start = 1'b1;
                state_next     = ST_ROUND;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: design/md5_dpath.sv
// MD5 datapath: block store, round unit, chaining words, counters, output register.
module md5_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        data_byte,
    input  md5_pkg::md5_cmd_t  cmd,
    output md5_pkg::md5_stat_t stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [md5_pkg::DIGEST_W-1:0] m_tdata
);
    import md5_pkg::*;

    logic [WORD_W-1:0]   blk_reg [16];
    logic [WORD_W-1:0]   chain_reg [4];
    logic [WORD_W-1:0]   chain_next [4];
    logic [WORD_W-1:0]   rw_reg [4];
    logic [WORD_W-1:0]   rw_next [4];
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [ROUND_W-1:0]  rnd_reg, rnd_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIGEST_W-1:0] out_data_reg, out_data_next;

    logic [3:0]          lo;
    logic [3:0]          g;
    logic [WORD_W-1:0]   f;
    logic [WORD_W-1:0]   raw_word;
    logic [WORD_W-1:0]   m_word;
    logic [63:0]         bit_count;
    logic [FILL_W-1:0]   pos;
    logic [WORD_W-1:0]   sum;
    logic [63:0]         rot_pair;
    logic [WORD_W-1:0]   rotated;
    logic [4:0]          shamt;

    assign bit_count = {count_reg, 3'b000};
    assign lo        = rnd_reg[3:0];
    assign raw_word  = blk_reg[g];

    // Message word index and round function per group of sixteen rounds.
    always_comb begin
        case (rnd_reg[5:4])
            2'd0: begin
                g = lo;
                f = (rw_reg[1] & rw_reg[2]) | (~rw_reg[1] & rw_reg[3]);
            end
            2'd1: begin
                g = 4'((lo << 2) + lo + 4'd1);
                f = (rw_reg[1] & rw_reg[3]) | (rw_reg[2] & ~rw_reg[3]);
            end
            2'd2: begin
                g = 4'((lo << 1) + lo + 4'd5);
                f = rw_reg[1] ^ rw_reg[2] ^ rw_reg[3];
            end
            default: begin
                g = 4'((lo << 3) - lo);
                f = rw_reg[2] ^ (rw_reg[1] | ~rw_reg[3]);
            end
        endcase
    end

    // Present padding and length on the fly instead of writing them into the store.
    always_comb begin
        m_word = raw_word;
        pos    = '0;
        for (int b = 0; b < 4; b++) begin
            pos = {g, 2'(b)};
            if (cmd.blk_mode == BLK_ZLEN) begin
                m_word[8*b +: 8] = 8'h00;
            end else if (cmd.blk_mode != BLK_DATA) begin
                if (pos == fill_reg) begin
                    m_word[8*b +: 8] = PAD_BYTE;
                end else if (pos > fill_reg) begin
                    m_word[8*b +: 8] = 8'h00;
                end
            end
        end
        if (cmd.blk_mode == BLK_PADLEN || cmd.blk_mode == BLK_ZLEN) begin
            if (g == 4'd14) begin
                m_word = bit_count[31:0];
            end else if (g == 4'd15) begin
                m_word = bit_count[63:32];
            end
        end
    end

    assign shamt    = ROT_S[{rnd_reg[5:4], rnd_reg[1:0]}];
    assign sum      = rw_reg[0] + f + m_word + SINE_K[rnd_reg];
    assign rot_pair = {sum, sum} << shamt;
    assign rotated  = rot_pair[63:32];

    always_comb begin
        rw_next        = rw_reg;
        chain_next     = chain_reg;
        rnd_next       = rnd_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cmd.byte_wr) begin
            fill_next  = fill_reg + FILL_W'(1);
            count_next = count_reg + COUNT_W'(1);
        end
        if (cmd.comp_start) begin
            rw_next  = chain_reg;
            rnd_next = '0;
        end
        if (cmd.round_step) begin
            rw_next[0] = rw_reg[3];
            rw_next[3] = rw_reg[2];
            rw_next[2] = rw_reg[1];
            rw_next[1] = rw_reg[1] + rotated;
            rnd_next   = rnd_reg + ROUND_W'(1);
        end
        if (cmd.chain_add) begin
            for (int i = 0; i < 4; i++) begin
                chain_next[i] = chain_reg[i] + rw_reg[i];
            end
        end
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};
            chain_next[0]  = INIT_A;
            chain_next[1]  = INIT_B;
            chain_next[2]  = INIT_C;
            chain_next[3]  = INIT_D;
            fill_next      = '0;
            count_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg[0]  <= INIT_A;
            chain_reg[1]  <= INIT_B;
            chain_reg[2]  <= INIT_C;
            chain_reg[3]  <= INIT_D;
            fill_reg      <= '0;
            count_reg     <= '0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            chain_reg     <= chain_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rw_reg       <= rw_next;
        out_data_reg <= out_data_next;
        if (cmd.byte_wr) begin
            blk_reg[fill_reg[5:2]][8*fill_reg[1:0] +: 8] <= data_byte;
        end
    end

    assign stat.fill_last  = (fill_reg == 6'd63);
    assign stat.fill_late  = (fill_reg[5:3] == 3'b111);
    assign stat.round_last = (rnd_reg == 6'd63);
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: design/md5_message_digest.sv
// Top level of the MD5 message digest engine.
//
// Input channel (s_*): one beat per message byte. s_tuser = 0 appends
// s_tdata[7:0] to the message; s_tuser = 1 ends the message and requests
// the digest (s_tdata is ignored on that beat).
// Result channel (m_*): one 128-bit beat per finished message; m_tdata
// carries chaining words A, B, C, D from bit 0 up (digest bytes 0..15).
// The 64th byte of a block starts a compression: one round per cycle on
// a shared round unit, then an add into the chaining words; s_tready is
// low during the rounds and the add. A finish beat runs one compression
// before the digest, or two when 56 or more bytes sit in the block. The
// digest is held in an output register; bytes of the next message are
// taken while it waits. If the receiver stalls and a second finish
// completes, the engine holds before emitting until the earlier digest
// is taken. After each digest the chaining words, fill position and
// length counter return to their initial values. Reset (aresetn low,
// synchronous) does the same and drops any pending digest beat.
module md5_message_digest (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // [63:0] digest_low, [127:64] digest_high
);
    import md5_pkg::*;

    md5_cmd_t  cmd;
    md5_stat_t stat;

    md5_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    md5_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .data_byte (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
